>>> sv/dhkv_pkg.sv
// Shared types and codes of the double-hash key/value table.
package dhkv_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_MISS     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [63:0] REG_FIRST_MULT  = 64'd0;
  localparam logic [63:0] REG_SECOND_MULT = 64'd1;
  localparam logic [63:0] REG_LOAD_LIMIT  = 64'd2;
  localparam logic [63:0] REG_KEY_BYTES   = 64'd3;

  localparam logic [63:0] FIRST_MULT_RESET  = 64'd15769474759331449193;
  localparam logic [63:0] SECOND_MULT_RESET = 64'd13659238136753279047;
  localparam logic [15:0] LOAD_LIMIT_RESET  = 16'd26214;
  localparam logic [3:0]  KEY_BYTES_RESET   = 4'd8;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CLR,
    B_CRD,
    B_CCHK,
    B_CHASH,
    B_PRD,
    B_PCHK,
    B_RD,
    B_CHK,
    B_DONE
  } back_state_t;

endpackage

>>> sv/dhkv_hash.sv
// Iterative multiplicative hash: home slot and odd probe step from one key.
module dhkv_hash #(
  parameter int LOG_SLOTS = 10,
  parameter int HASH_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          key,
  input  logic [63:0]          mult_a,
  input  logic [63:0]          mult_b,
  output logic                 done,
  output logic [LOG_SLOTS-1:0] home,
  output logic [LOG_SLOTS-1:0] step
);

  logic [63:0] key_r;
  logic [2:0]  cnt;
  logic        run;
  logic [63:0] prod;
  logic        pv;
  logic [1:0]  ppart;
  logic        pwhich;
  logic [63:0] acc;

  logic                 which_i;
  logic [1:0]           part_i;
  logic [63:0]          mo;
  logic [31:0]          op_a;
  logic [31:0]          op_b;
  logic [63:0]          acc_sum;
  logic [LOG_SLOTS-1:0] hbits;
  logic [LOG_SLOTS-1:0] odd_step;

  // Low 64 bits of a 64x64 product from three 32x32 partial products.
  always_comb begin
    which_i = (cnt >= 3'd3);
    part_i  = which_i ? 2'(cnt - 3'd3) : cnt[1:0];
    mo      = which_i ? mult_b : mult_a;
    op_a    = (part_i == 2'd2) ? key_r[63:32] : key_r[31:0];
    op_b    = (part_i == 2'd1) ? mo[63:32] : mo[31:0];
    acc_sum = acc + {prod[31:0], 32'd0};
    hbits   = acc_sum[HASH_BITS-1 -: LOG_SLOTS];
    if (hbits[0]) begin
      odd_step = hbits;
    end else if (hbits == '0) begin
      odd_step = LOG_SLOTS'(1);
    end else begin
      odd_step = hbits - LOG_SLOTS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          run <= 1'b0;
        end
      end
      pv   <= run;
      done <= pv && (ppart == 2'd2) && pwhich;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    prod   <= op_a * op_b;
    ppart  <= part_i;
    pwhich <= which_i;
    if (pv) begin
      if (ppart == 2'd0) begin
        acc <= prod;
      end else begin
        acc <= acc_sum;
      end
      if (ppart == 2'd2) begin
        if (pwhich) begin
          step <= odd_step;
        end else begin
          home <= hbits;
        end
      end
    end
  end

endmodule

>>> sv/dhkv_front.sv
// Front end: takes items, masks the key and computes its hashes.
module dhkv_front #(
  parameter int LOG_SLOTS = 10,
  parameter int HASH_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enable,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [63:0]          key,
  input  logic [63:0]          element_in,
  input  logic [63:0]          first_mult,
  input  logic [63:0]          second_mult,
  input  logic [3:0]           key_bytes,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [1:0]           q_mode,
  output logic [63:0]          q_key,
  output logic [63:0]          q_elem,
  output logic [LOG_SLOTS-1:0] q_home,
  output logic [LOG_SLOTS-1:0] q_step
);

  dhkv_pkg::front_state_t state, state_next;

  logic                 accept;
  logic [3:0]           kb;
  logic [63:0]          masked;
  logic                 hdone;
  logic [LOG_SLOTS-1:0] hhome;
  logic [LOG_SLOTS-1:0] hstep;

  assign accept = in_valid && in_ready;

  always_comb begin
    kb = (key_bytes == 4'd0) ? 4'd1 : key_bytes;
    for (int j = 0; j < 8; j++) begin
      masked[8*j +: 8] = (4'(j) < kb) ? key[8*j +: 8] : 8'd0;
    end
  end

  dhkv_hash #(.LOG_SLOTS(LOG_SLOTS), .HASH_BITS(HASH_BITS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .key    (masked),
    .mult_a (first_mult),
    .mult_b (second_mult),
    .done   (hdone),
    .home   (hhome),
    .step   (hstep)
  );

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_push     = 1'b0;
    case (state)
      dhkv_pkg::F_IDLE: begin
        in_ready = enable;
        if (accept) begin
          state_next = dhkv_pkg::F_HASH;
        end
      end
      dhkv_pkg::F_HASH: begin
        if (hdone) begin
          state_next = dhkv_pkg::F_PUSH;
        end
      end
      dhkv_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = dhkv_pkg::F_IDLE;
        end
      end
      default: state_next = dhkv_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhkv_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode <= mode;
      q_key  <= masked;
      q_elem <= element_in;
    end
    if (hdone) begin
      q_home <= hhome;
      q_step <= hstep;
    end
  end

endmodule

>>> sv/dhkv_fifo.sv
// Two-entry queue between the front end and the table engine.
module dhkv_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

>>> sv/dhkv_back.sv
// Table engine: slot memories, probe walks, bank cleaning and the result register.
module dhkv_back #(
  parameter int LOG_SLOTS = 10,
  parameter int HASH_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          first_mult,
  input  logic [63:0]          second_mult,
  input  logic [15:0]          load_limit,
  output logic                 init_done,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [1:0]           q_mode,
  input  logic [63:0]          q_key,
  input  logic [63:0]          q_elem,
  input  logic [LOG_SLOTS-1:0] q_home,
  input  logic [LOG_SLOTS-1:0] q_step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          element_out,
  output logic [2:0]           status
);

  localparam int NSLOTS = 1 << LOG_SLOTS;
  localparam int AW     = LOG_SLOTS + 1;

  localparam logic [LOG_SLOTS:0]   N_FULL   = (LOG_SLOTS+1)'(NSLOTS);
  localparam logic [LOG_SLOTS-1:0] LAST_IX  = LOG_SLOTS'(NSLOTS - 1);
  localparam logic [AW-1:0]        LAST_ALL = AW'(2 * NSLOTS - 1);

  logic [1:0]  tag_mem  [2*NSLOTS];
  logic [63:0] key_mem  [2*NSLOTS];
  logic [63:0] elem_mem [2*NSLOTS];

  dhkv_pkg::back_state_t state, state_next;

  logic [AW-1:0]        sweep, sweep_next;
  logic [LOG_SLOTS-1:0] ix, ix_next;
  logic [LOG_SLOTS-1:0] d, d_next;
  logic [LOG_SLOTS:0]   n, n_next;
  logic                 bank, bank_next;
  logic [LOG_SLOTS:0]   live, live_next;
  logic [LOG_SLOTS:0]   tomb, tomb_next;
  logic [LOG_SLOTS:0]   plim, plim_next;
  logic [1:0]           cmode, cmode_next;
  logic [63:0]          ckey, ckey_next;
  logic [63:0]          celem, celem_next;
  logic [LOG_SLOTS-1:0] chome, chome_next;
  logic [LOG_SLOTS-1:0] cstep, cstep_next;
  logic [63:0]          mkey, mkey_next;
  logic [63:0]          melem, melem_next;
  logic [63:0]          rel, rel_next;
  logic [2:0]           rst_code, rst_code_next;
  logic                 out_valid_next;
  logic [63:0]          element_out_next;
  logic [2:0]           status_next;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          we_tag;
  logic          we_key;
  logic          we_elem;
  logic [1:0]    wr_tag;
  logic [63:0]   wr_key;
  logic [63:0]   wr_elem;
  logic [1:0]    tag_q;
  logic [63:0]   key_q;
  logic [63:0]   elem_q;

  logic                   hstart;
  logic                   hdone;
  logic [LOG_SLOTS-1:0]   hhome;
  logic [LOG_SLOTS-1:0]   hstep;
  logic [LOG_SLOTS+1:0]   used;
  logic [LOG_SLOTS+17:0]  load_lhs;
  logic [LOG_SLOTS+17:0]  load_rhs;
  logic                   need_clean;

  assign init_done = (state != dhkv_pkg::B_INIT);

  always_comb begin
    used       = {1'b0, live} + {1'b0, tomb};
    load_lhs   = {used, 16'd0};
    load_rhs   = {2'd0, load_limit, {LOG_SLOTS{1'b0}}};
    need_clean = (load_lhs > load_rhs) && (live < tomb);
  end

  dhkv_hash #(.LOG_SLOTS(LOG_SLOTS), .HASH_BITS(HASH_BITS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hstart),
    .key    (key_q),
    .mult_a (first_mult),
    .mult_b (second_mult),
    .done   (hdone),
    .home   (hhome),
    .step   (hstep)
  );

  always_comb begin
    state_next       = state;
    sweep_next       = sweep;
    ix_next          = ix;
    d_next           = d;
    n_next           = n;
    bank_next        = bank;
    live_next        = live;
    tomb_next        = tomb;
    plim_next        = plim;
    cmode_next       = cmode;
    ckey_next        = ckey;
    celem_next       = celem;
    chome_next       = chome;
    cstep_next       = cstep;
    mkey_next        = mkey;
    melem_next       = melem;
    rel_next         = rel;
    rst_code_next    = rst_code;
    out_valid_next   = out_valid && !out_ready;
    element_out_next = element_out;
    status_next      = status;
    q_pop            = 1'b0;
    hstart           = 1'b0;
    rd_addr          = {bank, ix};
    wr_addr          = {bank, ix};
    we_tag           = 1'b0;
    we_key           = 1'b0;
    we_elem          = 1'b0;
    wr_tag           = dhkv_pkg::TAG_EMPTY;
    wr_key           = ckey;
    wr_elem          = celem;

    case (state)
      dhkv_pkg::B_INIT: begin
        wr_addr = sweep;
        we_tag  = 1'b1;
        if (sweep == LAST_ALL) begin
          sweep_next = '0;
          state_next = dhkv_pkg::B_IDLE;
        end else begin
          sweep_next = sweep + AW'(1);
        end
      end

      dhkv_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cmode_next = q_mode;
          ckey_next  = q_key;
          celem_next = q_elem;
          chome_next = q_home;
          cstep_next = q_step;
          ix_next    = q_home;
          d_next     = q_step;
          n_next     = (LOG_SLOTS+1)'(1);
          if (q_mode == dhkv_pkg::MODE_INSERT && need_clean) begin
            sweep_next = '0;
            live_next  = '0;
            tomb_next  = '0;
            plim_next  = (LOG_SLOTS+1)'(1);
            state_next = dhkv_pkg::B_CLR;
          end else if (q_mode == dhkv_pkg::MODE_INSERT || q_mode == dhkv_pkg::MODE_SEARCH ||
                       q_mode == dhkv_pkg::MODE_REMOVE) begin
            state_next = dhkv_pkg::B_RD;
          end else begin
            rel_next      = '0;
            rst_code_next = dhkv_pkg::ST_MISS;
            state_next    = dhkv_pkg::B_DONE;
          end
        end
      end

      dhkv_pkg::B_CLR: begin
        wr_addr = {~bank, sweep[LOG_SLOTS-1:0]};
        we_tag  = 1'b1;
        if (sweep[LOG_SLOTS-1:0] == LAST_IX) begin
          sweep_next = '0;
          state_next = dhkv_pkg::B_CRD;
        end else begin
          sweep_next = sweep + AW'(1);
        end
      end

      dhkv_pkg::B_CRD: begin
        rd_addr    = {bank, sweep[LOG_SLOTS-1:0]};
        state_next = dhkv_pkg::B_CCHK;
      end

      dhkv_pkg::B_CCHK, dhkv_pkg::B_PCHK: begin
        if (state == dhkv_pkg::B_CCHK && tag_q == dhkv_pkg::TAG_LIVE) begin
          mkey_next  = key_q;
          melem_next = elem_q;
          hstart     = 1'b1;
          state_next = dhkv_pkg::B_CHASH;
        end else if (state == dhkv_pkg::B_PCHK && tag_q != dhkv_pkg::TAG_EMPTY &&
                     n != N_FULL) begin
          ix_next    = ix + d;
          n_next     = n + (LOG_SLOTS+1)'(1);
          state_next = dhkv_pkg::B_PRD;
        end else begin
          if (state == dhkv_pkg::B_PCHK && tag_q == dhkv_pkg::TAG_EMPTY) begin
            wr_addr   = {~bank, ix};
            we_tag    = 1'b1;
            we_key    = 1'b1;
            we_elem   = 1'b1;
            wr_tag    = dhkv_pkg::TAG_LIVE;
            wr_key    = mkey;
            wr_elem   = melem;
            live_next = live + (LOG_SLOTS+1)'(1);
            if (n > plim) begin
              plim_next = n;
            end
          end
          // Move on to the next slot of the old bank, or finish the clean.
          if (sweep[LOG_SLOTS-1:0] == LAST_IX) begin
            bank_next  = ~bank;
            ix_next    = chome;
            d_next     = cstep;
            n_next     = (LOG_SLOTS+1)'(1);
            state_next = dhkv_pkg::B_RD;
          end else begin
            sweep_next = sweep + AW'(1);
            state_next = dhkv_pkg::B_CRD;
          end
        end
      end

      dhkv_pkg::B_CHASH: begin
        if (hdone) begin
          ix_next    = hhome;
          d_next     = hstep;
          n_next     = (LOG_SLOTS+1)'(1);
          state_next = dhkv_pkg::B_PRD;
        end
      end

      dhkv_pkg::B_PRD: begin
        rd_addr    = {~bank, ix};
        state_next = dhkv_pkg::B_PCHK;
      end

      dhkv_pkg::B_RD: begin
        rd_addr    = {bank, ix};
        state_next = dhkv_pkg::B_CHK;
      end

      dhkv_pkg::B_CHK: begin
        state_next = dhkv_pkg::B_DONE;
        rel_next   = '0;
        if (cmode == dhkv_pkg::MODE_INSERT) begin
          if (tag_q == dhkv_pkg::TAG_EMPTY) begin
            we_tag        = 1'b1;
            we_key        = 1'b1;
            we_elem       = 1'b1;
            wr_tag        = dhkv_pkg::TAG_LIVE;
            live_next     = live + (LOG_SLOTS+1)'(1);
            rst_code_next = dhkv_pkg::ST_NEW;
            if (n > plim) begin
              plim_next = n;
            end
          end else if (tag_q == dhkv_pkg::TAG_LIVE && key_q == ckey) begin
            we_elem       = 1'b1;
            rst_code_next = dhkv_pkg::ST_REPLACED;
            if (n > plim) begin
              plim_next = n;
            end
          end else if (n == N_FULL) begin
            rst_code_next = dhkv_pkg::ST_FULL;
          end else begin
            ix_next    = ix + d;
            n_next     = n + (LOG_SLOTS+1)'(1);
            state_next = dhkv_pkg::B_RD;
          end
        end else begin
          if (tag_q == dhkv_pkg::TAG_EMPTY) begin
            rst_code_next = dhkv_pkg::ST_MISS;
          end else if (tag_q == dhkv_pkg::TAG_LIVE && key_q == ckey) begin
            rel_next      = elem_q;
            rst_code_next = dhkv_pkg::ST_HIT;
            if (cmode == dhkv_pkg::MODE_REMOVE) begin
              we_tag    = 1'b1;
              wr_tag    = dhkv_pkg::TAG_TOMB;
              live_next = live - (LOG_SLOTS+1)'(1);
              tomb_next = tomb + (LOG_SLOTS+1)'(1);
            end
          end else if (n >= plim || n == N_FULL) begin
            rst_code_next = dhkv_pkg::ST_MISS;
          end else begin
            ix_next    = ix + d;
            n_next     = n + (LOG_SLOTS+1)'(1);
            state_next = dhkv_pkg::B_RD;
          end
        end
      end

      dhkv_pkg::B_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          element_out_next = rel;
          status_next      = rst_code;
          state_next       = dhkv_pkg::B_IDLE;
        end
      end

      default: state_next = dhkv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dhkv_pkg::B_INIT;
      sweep     <= '0;
      bank      <= 1'b0;
      live      <= '0;
      tomb      <= '0;
      plim      <= (LOG_SLOTS+1)'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      bank      <= bank_next;
      live      <= live_next;
      tomb      <= tomb_next;
      plim      <= plim_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ix          <= ix_next;
    d           <= d_next;
    n           <= n_next;
    cmode       <= cmode_next;
    ckey        <= ckey_next;
    celem       <= celem_next;
    chome       <= chome_next;
    cstep       <= cstep_next;
    mkey        <= mkey_next;
    melem       <= melem_next;
    rel         <= rel_next;
    rst_code    <= rst_code_next;
    element_out <= element_out_next;
    status      <= status_next;
  end

  always_ff @(posedge clk) begin
    if (we_tag) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (we_key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (we_elem) begin
      elem_mem[wr_addr] <= wr_elem;
    end
    tag_q  <= tag_mem[rd_addr];
    key_q  <= key_mem[rd_addr];
    elem_q <= elem_mem[rd_addr];
  end

endmodule

>>> sv/double_hash_key_value_table_top.sv
// Usage: a key/value table with double-hashing probes in two banks of slots.
// Input channel (in_valid/in_ready) carries mode, key and element_in; each
// transfer yields exactly one result on the output channel (out_valid/
// out_ready) with element_out and status. The config channel (cfg_valid/
// cfg_ready, always ready) writes cfg_data to register cfg_index: 0 first
// multiplier, 1 second multiplier, 2 load limit, 3 key bytes. Write it only
// while the table is idle.
// The front end hashes a key with one 32x32 multiplier, then pushes it into
// the queue and only then accepts again; it can take the next item while the
// engine still works on earlier ones. The engine dispatches an item from the
// queue, reads memory and then decides for each probed slot, and finally
// loads the result register.
// An insert that triggers cleaning first sweeps the other bank, then reads
// every old slot and rehashes each live key into the other bank.
// After reset the engine clears all tags of both banks with in_ready low.
// A stalled output holds its result; the engine waits only when it has a new
// result to load, while the front end keeps accepting until the queue is full.
module double_hash_key_value_table_top #(
  parameter int LOG_SLOTS = 10,
  parameter int HASH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [63:0] element_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] element_out,
  output logic [2:0]  status
);

  localparam int QW = 2 + 64 + 64 + 2 * LOG_SLOTS;

  logic [63:0] first_mult;
  logic [63:0] second_mult;
  logic [15:0] load_limit;
  logic [3:0]  key_bytes;
  logic        init_done;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  logic [1:0]           f_mode;
  logic [63:0]          f_key;
  logic [63:0]          f_elem;
  logic [LOG_SLOTS-1:0] f_home;
  logic [LOG_SLOTS-1:0] f_step;
  logic [QW-1:0]        q_din;
  logic [QW-1:0]        q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_mult  <= dhkv_pkg::FIRST_MULT_RESET;
      second_mult <= dhkv_pkg::SECOND_MULT_RESET;
      load_limit  <= dhkv_pkg::LOAD_LIMIT_RESET;
      key_bytes   <= dhkv_pkg::KEY_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dhkv_pkg::REG_FIRST_MULT:  first_mult  <= cfg_data;
        dhkv_pkg::REG_SECOND_MULT: second_mult <= cfg_data;
        dhkv_pkg::REG_LOAD_LIMIT:  load_limit  <= cfg_data[15:0];
        dhkv_pkg::REG_KEY_BYTES:   key_bytes   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  dhkv_front #(.LOG_SLOTS(LOG_SLOTS), .HASH_BITS(HASH_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .enable      (init_done),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .key         (key),
    .element_in  (element_in),
    .first_mult  (first_mult),
    .second_mult (second_mult),
    .key_bytes   (key_bytes),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_mode      (f_mode),
    .q_key       (f_key),
    .q_elem      (f_elem),
    .q_home      (f_home),
    .q_step      (f_step)
  );

  assign q_din = {f_mode, f_key, f_elem, f_home, f_step};

  dhkv_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  dhkv_back #(.LOG_SLOTS(LOG_SLOTS), .HASH_BITS(HASH_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .first_mult  (first_mult),
    .second_mult (second_mult),
    .load_limit  (load_limit),
    .init_done   (init_done),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_mode      (q_dout[QW-1 -: 2]),
    .q_key       (q_dout[QW-3 -: 64]),
    .q_elem      (q_dout[QW-67 -: 64]),
    .q_home      (q_dout[2*LOG_SLOTS-1 -: LOG_SLOTS]),
    .q_step      (q_dout[LOG_SLOTS-1:0]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .element_out (element_out),
    .status      (status)
  );

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !in_ready)
    else $error("input accepted during tag clearing");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= dhkv_pkg::ST_FULL))
    else $error("result status out of range");

  a_elem_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != dhkv_pkg::ST_HIT) |-> (element_out == 64'd0))
    else $error("element returned without a hit");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

>>> tb/double_hash_key_value_table_top_test.sv
// Self-checking test of the double-hash key/value table against a behavioral model.
module double_hash_key_value_table_top_test;

  localparam int LOG_N = 10;
  localparam int NS = 1 << LOG_N;
  localparam int WATCH_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [63:0] key = '0;
  logic [63:0] element_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] element_out;
  logic [2:0] status;

  double_hash_key_value_table_top #(.LOG_SLOTS(LOG_N), .HASH_BITS(64)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .key(key),
    .element_in(element_in),
    .out_valid(out_valid), .out_ready(out_ready), .element_out(element_out),
    .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state of the table.
  logic [63:0] m_mult1, m_mult2;
  logic [15:0] m_limit;
  logic [3:0] m_kbytes;
  logic [1:0] m_tag [2*NS];
  logic [63:0] m_key [2*NS];
  logic [63:0] m_elem [2*NS];
  int m_bank, m_live, m_tomb, m_plimit;

  logic [63:0] want_elem_q [$];
  logic [2:0] want_status_q [$];
  logic [63:0] live_keys [$];
  int mismatches = 0;
  int idle_send = 0;
  int stall_recv = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] masked_key(logic [63:0] k);
    int b;
    b = (m_kbytes == 0) ? 1 : m_kbytes;
    if (b >= 8) return k;
    return k & ((64'd1 << (8 * b)) - 64'd1);
  endfunction

  function automatic int home_of(logic [63:0] k);
    logic [63:0] h;
    h = m_mult1 * k;
    return int'(h[63:64-LOG_N]);
  endfunction

  function automatic int step_of(logic [63:0] k);
    logic [63:0] h;
    int d;
    h = m_mult2 * k;
    d = int'(h[63:64-LOG_N]);
    if (d % 2 == 0) d = (d == 0) ? 1 : d - 1;
    return d;
  endfunction

  function automatic void rehash_bank();
    int ob, nb, ix, d, n;
    ob = m_bank;
    nb = ob ^ 1;
    for (int i = 0; i < NS; i++) m_tag[nb*NS+i] = dhkv_pkg::TAG_EMPTY;
    m_live = 0;
    m_tomb = 0;
    m_plimit = 1;
    for (int i = 0; i < NS; i++) begin
      if (m_tag[ob*NS+i] == dhkv_pkg::TAG_LIVE) begin
        ix = home_of(m_key[ob*NS+i]);
        d = step_of(m_key[ob*NS+i]);
        for (n = 1; n <= NS; n++) begin
          if (m_tag[nb*NS+ix] == dhkv_pkg::TAG_EMPTY) begin
            m_tag[nb*NS+ix] = dhkv_pkg::TAG_LIVE;
            m_key[nb*NS+ix] = m_key[ob*NS+i];
            m_elem[nb*NS+ix] = m_elem[ob*NS+i];
            m_live++;
            if (n > m_plimit) m_plimit = n;
            break;
          end
          ix = (ix + d) % NS;
        end
      end
    end
    m_bank = nb;
  endfunction

  // Predicts the result of one operation and updates the model state.
  function automatic void predict_table_op(logic [1:0] md, logic [63:0] kin, logic [63:0] ein);
    logic [63:0] k, e_out;
    logic [2:0] st;
    int base, ix, d, n, hit;
    k = masked_key(kin);
    e_out = '0;
    st = dhkv_pkg::ST_MISS;
    if (md == dhkv_pkg::MODE_INSERT) begin
      if ((longint'(m_live + m_tomb) << 16) > (longint'(m_limit) << LOG_N) && m_live < m_tomb)
        rehash_bank();
      base = m_bank * NS;
      ix = home_of(k);
      d = step_of(k);
      st = dhkv_pkg::ST_FULL;
      for (n = 1; n <= NS; n++) begin
        if (m_tag[base+ix] == dhkv_pkg::TAG_EMPTY) begin
          m_tag[base+ix] = dhkv_pkg::TAG_LIVE;
          m_key[base+ix] = k;
          m_elem[base+ix] = ein;
          m_live++;
          if (n > m_plimit) m_plimit = n;
          st = dhkv_pkg::ST_NEW;
          break;
        end
        if (m_tag[base+ix] == dhkv_pkg::TAG_LIVE && m_key[base+ix] == k) begin
          m_elem[base+ix] = ein;
          if (n > m_plimit) m_plimit = n;
          st = dhkv_pkg::ST_REPLACED;
          break;
        end
        ix = (ix + d) % NS;
      end
    end else if (md == dhkv_pkg::MODE_SEARCH || md == dhkv_pkg::MODE_REMOVE) begin
      base = m_bank * NS;
      ix = home_of(k);
      d = step_of(k);
      hit = -1;
      for (n = 1; n <= NS; n++) begin
        if (m_tag[base+ix] == dhkv_pkg::TAG_EMPTY) break;
        if (m_tag[base+ix] == dhkv_pkg::TAG_LIVE && m_key[base+ix] == k) begin
          hit = base + ix;
          break;
        end
        if (n >= m_plimit) break;
        ix = (ix + d) % NS;
      end
      if (hit >= 0) begin
        e_out = m_elem[hit];
        st = dhkv_pkg::ST_HIT;
        if (md == dhkv_pkg::MODE_REMOVE) begin
          m_tag[hit] = dhkv_pkg::TAG_TOMB;
          m_live--;
          m_tomb++;
        end
      end
    end
    want_elem_q.push_back(e_out);
    want_status_q.push_back(st);
  endfunction

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send_op(logic [1:0] md, logic [63:0] k, logic [63:0] e);
    while (idle_send > 0 && $urandom_range(99) < idle_send) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    mode <= md;
    key <= k;
    element_in <= e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table_op(md, k, e);
    if (md == dhkv_pkg::MODE_INSERT) live_keys.push_back(k);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (want_status_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [63:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dhkv_pkg::REG_FIRST_MULT: m_mult1 = val;
      dhkv_pkg::REG_SECOND_MULT: m_mult2 = val;
      dhkv_pkg::REG_LOAD_LIMIT: m_limit = val[15:0];
      dhkv_pkg::REG_KEY_BYTES: m_kbytes = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver side: random stall and result comparison.
  always @(negedge clk) begin
    if (!rst) out_ready <= !(stall_recv > 0 && $urandom_range(99) < stall_recv);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (want_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d elem %h", status, element_out);
      end else begin
        if (status !== want_status_q[0] || element_out !== want_elem_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, elem exp %h got %h",
                     want_status_q[0], status, want_elem_q[0], element_out);
        end
        void'(want_status_q.pop_front());
        void'(want_elem_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(99) < 60)
      return live_keys[$urandom_range(live_keys.size() - 1)];
    case ($urandom_range(3))
      0: return 64'(($urandom_range(63)));
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic test_directed();
    send_op(dhkv_pkg::MODE_SEARCH, 64'd5, 64'd0);
    send_op(dhkv_pkg::MODE_INSERT, 64'd0, '1);
    send_op(dhkv_pkg::MODE_INSERT, '1, 64'h1234);
    send_op(dhkv_pkg::MODE_INSERT, '1, 64'h5678);
    send_op(dhkv_pkg::MODE_SEARCH, '1, 64'd0);
    send_op(dhkv_pkg::MODE_SEARCH, 64'd0, 64'd0);
    send_op(dhkv_pkg::MODE_REMOVE, '1, 64'd0);
    send_op(dhkv_pkg::MODE_REMOVE, '1, 64'd0);
    send_op(dhkv_pkg::MODE_SEARCH, '1, 64'd0);
    send_op(dhkv_pkg::MODE_NONE, 64'd0, '1);
    send_op(dhkv_pkg::MODE_INSERT, 64'h8000_0000_0000_0001, 64'hAAAA_5555_AAAA_5555);
    send_op(dhkv_pkg::MODE_SEARCH, 64'h8000_0000_0000_0001, 64'd0);
    drain();
  endtask

  task automatic test_random(int count);
    int r;
    logic [1:0] md;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      md = (r < 45) ? dhkv_pkg::MODE_INSERT :
           (r < 70) ? dhkv_pkg::MODE_SEARCH :
           (r < 97) ? dhkv_pkg::MODE_REMOVE : dhkv_pkg::MODE_NONE;
      send_op(md, pick_key(), rand64());
    end
    drain();
  endtask

  // Many inserts then removes to push load and tombstones into the cleaning path.
  task automatic test_cleaning();
    logic [63:0] k;
    write_reg(dhkv_pkg::REG_LOAD_LIMIT, 64'd1);
    for (int i = 0; i < 30; i++) send_op(dhkv_pkg::MODE_INSERT, 64'(i * 7 + 3), rand64());
    for (int i = 0; i < 25; i++) send_op(dhkv_pkg::MODE_REMOVE, 64'(i * 7 + 3), 64'd0);
    for (int i = 0; i < 10; i++) begin
      k = 64'(i * 7 + 3);
      send_op(dhkv_pkg::MODE_INSERT, k + 64'd1000, rand64());
      send_op(dhkv_pkg::MODE_SEARCH, 64'(i * 7 + 178), 64'd0);
    end
    drain();
  endtask

  // Tiny key width and degenerate multipliers fill a small key space.
  task automatic test_narrow_keys();
    write_reg(dhkv_pkg::REG_KEY_BYTES, 64'd1);
    write_reg(dhkv_pkg::REG_FIRST_MULT, 64'd0);
    write_reg(dhkv_pkg::REG_SECOND_MULT, 64'd0);
    for (int i = 0; i < 20; i++) send_op(dhkv_pkg::MODE_INSERT, rand64(), rand64());
    drain();
    write_reg(dhkv_pkg::REG_KEY_BYTES, 64'd0);
    write_reg(dhkv_pkg::REG_FIRST_MULT, '1);
    write_reg(dhkv_pkg::REG_SECOND_MULT, 64'd2);
    test_random(40);
    write_reg(dhkv_pkg::REG_KEY_BYTES, 64'd15);
    write_reg(dhkv_pkg::REG_LOAD_LIMIT, 64'hFFFF);
    test_random(30);
    write_reg(dhkv_pkg::REG_FIRST_MULT, dhkv_pkg::FIRST_MULT_RESET);
    write_reg(dhkv_pkg::REG_SECOND_MULT, dhkv_pkg::SECOND_MULT_RESET);
    write_reg(dhkv_pkg::REG_LOAD_LIMIT, 64'(dhkv_pkg::LOAD_LIMIT_RESET));
    write_reg(dhkv_pkg::REG_KEY_BYTES, 64'(dhkv_pkg::KEY_BYTES_RESET));
  endtask

  task automatic test_idling();
    idle_send = 57; stall_recv = 0;
    test_random(70);
    idle_send = 0; stall_recv = 57;
    test_random(70);
    idle_send = 30; stall_recv = 30;
    test_random(70);
    idle_send = 0; stall_recv = 0;
    test_random(60);
  endtask

  initial begin
    m_mult1 = dhkv_pkg::FIRST_MULT_RESET;
    m_mult2 = dhkv_pkg::SECOND_MULT_RESET;
    m_limit = dhkv_pkg::LOAD_LIMIT_RESET;
    m_kbytes = dhkv_pkg::KEY_BYTES_RESET;
    for (int i = 0; i < 2*NS; i++) begin
      m_tag[i] = dhkv_pkg::TAG_EMPTY;
      m_key[i] = '0;
      m_elem[i] = '0;
    end
    m_bank = 0; m_live = 0; m_tomb = 0; m_plimit = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(20);
    test_cleaning();
    test_narrow_keys();
    test_idling();
    if (mismatches == 0 && want_status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/dhkv_pkg.sv
sv/dhkv_hash.sv
sv/dhkv_front.sv
sv/dhkv_fifo.sv
sv/dhkv_back.sv
sv/double_hash_key_value_table_top.sv
tb/double_hash_key_value_table_top_test.sv
